[hdl/mcb_pkg.sv]
// mcb_pkg: shared constants, codes, state encoding and command/status structs
// for the maze carver; no dependencies, compiled first
package mcb_pkg;

    // grid limits; the grid never holds more than CELL_DEPTH cells
    localparam int MAX_COLUMNS = 32;
    localparam int MAX_ROWS    = 32;
    localparam int CELL_DEPTH  = 1024;

    localparam int CELL_W    = $clog2(CELL_DEPTH);
    localparam int DEPTH_W   = CELL_W + 1;
    localparam int COL_W     = $clog2(MAX_COLUMNS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int TOTAL_W   = 2 * CFG_W;
    localparam int WALL_W    = 4;
    localparam int WORD_W    = WALL_W + 1;
    localparam int SCAN_W    = 3;

    // opcodes
    localparam logic [1:0] OP_CARVE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

    // wall / neighbour directions
    localparam logic [1:0] DIR_TOP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT  = 2'd1;
    localparam logic [1:0] DIR_BOTTOM = 2'd2;
    localparam logic [1:0] DIR_LEFT   = 2'd3;

    // scan slots: current cell first, then the four neighbours
    localparam logic [SCAN_W-1:0] SCAN_CUR  = 3'd0;
    localparam logic [SCAN_W-1:0] SCAN_LAST = 3'd4;

    localparam logic [WALL_W-1:0] WALLS_ALL = 4'hF;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_CHECK,
        ST_DIV,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_CARVE,
        ST_POP,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_item;
        logic clear_step;
        logic restart;
        logic zero_cur;
        logic div_start;
        logic div_load;
        logic scan_step;
        logic decide;
        logic carve;
        logic pop_load;
        logic fetch;
        logic fetch_take;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       cur_out;
        logic       geom_valid;
        logic       clr_last;
        logic       scan_last;
        logic       any_cand;
        logic       stack_empty;
        logic       out_free;
    } t_stat;

    // candidate index = pick mod count, count in 1..4
    function automatic logic [1:0] pick_index(input logic [2:0] count, input logic [1:0] pick);
        logic [1:0] k;
        case (count)
            3'd1:    k = 2'd0;
            3'd2:    k = {1'b0, pick[0]};
            3'd3:    k = (pick == 2'd3) ? 2'd0 : pick;
            default: k = pick;
        endcase
        return k;
    endfunction

endpackage

[hdl/mcb_item_if.sv]
// mcb_item_if: input channel of the maze carver, valid/ready plus item fields
// depends on mcb_pkg for field widths
interface mcb_item_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  opcode;
    logic [1:0]                  pick;
    logic [mcb_pkg::CELL_W-1:0]  cell_address;

    modport source (output valid, output opcode, output pick, output cell_address, input ready);
    modport sink   (input valid, input opcode, input pick, input cell_address, output ready);
endinterface

[hdl/mcb_res_if.sv]
// mcb_res_if: result channel of the maze carver, valid/ready plus result fields
// depends on mcb_pkg for field widths
interface mcb_res_if;
    logic                        valid;
    logic                        ready;
    logic [mcb_pkg::CELL_W-1:0]  position;
    logic                        carved;
    logic                        backtracked;
    logic                        finished;
    logic [mcb_pkg::WALL_W-1:0]  wall_bits;

    modport source (output valid, output position, output carved, output backtracked,
                    output finished, output wall_bits, input ready);
    modport sink   (input valid, input position, input carved, input backtracked,
                    input finished, input wall_bits, output ready);
endinterface

[hdl/mcb_div.sv]
// mcb_div: restoring divider, one quotient bit per cycle, splits a cell index
// into row and column; depends on mcb_pkg
module mcb_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mcb_pkg::CELL_W-1:0]  i_dividend,
    input  logic [mcb_pkg::CFG_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [mcb_pkg::CELL_W-1:0]  o_quotient,
    output logic [mcb_pkg::CFG_W-1:0]   o_remainder
);
    import mcb_pkg::*;

    localparam int CNT_W = $clog2(CELL_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CELL_W-1:0] r_quo;
    logic [CFG_W-1:0]  r_rem;
    logic [CFG_W-1:0]  r_den;

    logic [CFG_W:0] shifted;
    logic           ge;

    assign shifted = {r_rem, r_quo[CELL_W-1]};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(CELL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[CELL_W-2:0], ge};
            r_rem <= ge ? CFG_W'(shifted - {1'b0, r_den}) : shifted[CFG_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[hdl/mcb_ctrl.sv]
// mcb_ctrl: sequencer of the maze carver, issues one command set per state
// depends on mcb_pkg for t_state, t_cmd, t_stat and opcodes
module mcb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  logic           i_div_done,
    input  mcb_pkg::t_stat i_stat,
    output mcb_pkg::t_cmd  o_cmd,
    output logic           o_item_ready
);
    import mcb_pkg::*;

    t_state r_state, n_state;
    logic   r_restart, n_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_restart <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_restart <= n_restart;
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_restart = r_restart;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state   = r_restart ? ST_FETCH : ST_IDLE;
                    n_restart = 1'b0;
                end
            end
            ST_IDLE: begin
                if (i_item_valid) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (i_stat.op)
                    OP_CARVE: n_state = ST_CHECK;
                    OP_RESTART: begin
                        n_state   = ST_CLEAR;
                        n_restart = 1'b1;
                    end
                    default: n_state = ST_FETCH;
                endcase
            end
            ST_CHECK: begin
                if (!i_stat.cur_out && !i_stat.geom_valid) n_state = ST_DIV;
                else n_state = ST_SCAN;
            end
            ST_DIV: begin
                if (i_div_done) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.scan_last) n_state = ST_SCAN_END;
            end
            ST_SCAN_END: n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (i_stat.any_cand) n_state = ST_CARVE;
                else if (!i_stat.stack_empty) n_state = ST_POP;
                else n_state = ST_EMIT;
            end
            ST_CARVE:      n_state = ST_EMIT;
            ST_POP:        n_state = ST_FETCH;
            ST_FETCH:      n_state = ST_FETCH_WAIT;
            ST_FETCH_WAIT: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd        = '0;
        o_item_ready = 1'b0;
        case (r_state)
            ST_CLEAR: o_cmd.clear_step = 1'b1;
            ST_IDLE: begin
                o_item_ready    = 1'b1;
                o_cmd.load_item = i_item_valid;
            end
            ST_DISPATCH: o_cmd.restart = (i_stat.op == OP_RESTART);
            ST_CHECK: begin
                o_cmd.zero_cur  = i_stat.cur_out;
                o_cmd.div_start = !i_stat.cur_out && !i_stat.geom_valid;
            end
            ST_DIV:        o_cmd.div_load   = i_div_done;
            ST_SCAN:       o_cmd.scan_step  = 1'b1;
            ST_DECIDE:     o_cmd.decide     = 1'b1;
            ST_CARVE:      o_cmd.carve      = 1'b1;
            ST_POP:        o_cmd.pop_load   = 1'b1;
            ST_FETCH:      o_cmd.fetch      = 1'b1;
            ST_FETCH_WAIT: o_cmd.fetch_take = 1'b1;
            ST_EMIT:       o_cmd.emit       = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

[hdl/mcb_dp.sv]
// mcb_dp: datapath of the maze carver: cell memory (visited + walls), trail
// stack, position tracking, neighbour scan and result register; uses mcb_pkg
module mcb_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mcb_pkg::t_cmd                  i_cmd,
    output mcb_pkg::t_stat                 o_stat,
    input  logic [1:0]                     i_opcode,
    input  logic [1:0]                     i_pick,
    input  logic [mcb_pkg::CELL_W-1:0]     i_cell_address,
    input  logic                           i_cfg_we,
    input  logic [mcb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mcb_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [mcb_pkg::CELL_W-1:0]     i_div_quotient,
    input  logic [mcb_pkg::CFG_W-1:0]      i_div_remainder,
    output logic [mcb_pkg::CELL_W-1:0]     o_div_dividend,
    output logic [mcb_pkg::CFG_W-1:0]      o_div_divisor,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [mcb_pkg::CELL_W-1:0]     o_position,
    output logic                           o_carved,
    output logic                           o_backtracked,
    output logic                           o_finished,
    output logic [mcb_pkg::WALL_W-1:0]     o_wall_bits
);
    import mcb_pkg::*;

    // configuration and position state
    logic [CFG_W-1:0]   r_cols_cfg, r_rows_cfg;
    logic [CELL_W-1:0]  r_cur;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic               r_geom_valid;
    logic [DEPTH_W-1:0] r_depth;
    logic [CELL_W-1:0]  r_clr_cnt;
    logic [SCAN_W-1:0]  r_scan;
    logic               r_cap_vld;
    logic               r_out_valid;

    // item and working registers
    logic [1:0]         r_op;
    logic [1:0]         r_pick;
    logic [CELL_W-1:0]  r_addr;
    logic [SCAN_W-1:0]  r_cap_idx;
    logic [WORD_W-1:0]  r_slot [5];
    logic [CELL_W-1:0]  r_nxt;
    logic [1:0]         r_dir;
    logic [WALL_W-1:0]  r_nxt_walls;
    logic               r_carved, r_backtracked, r_finished;
    logic [WALL_W-1:0]  r_res_walls;
    logic [CELL_W-1:0]  r_out_pos;
    logic               r_out_carved, r_out_backtracked, r_out_finished;
    logic [WALL_W-1:0]  r_out_walls;

    // memories: cell word is {visited, walls}
    logic [WORD_W-1:0]  m_cell  [CELL_DEPTH];
    logic [CELL_W-1:0]  m_trail [CELL_DEPTH];
    logic [WORD_W-1:0]  r_mem_q;
    logic [CELL_W-1:0]  r_trail_q;

    logic [CFG_W-1:0]   cols_act, rows_act;
    logic [TOTAL_W-1:0] total;
    logic               cur_out;
    logic [3:0]         in_grid;
    logic [CELL_W-1:0]  nb_addr [4];
    logic [1:0]         scan_dir;
    logic [CELL_W-1:0]  scan_addr;
    logic [3:0]         cand;
    logic [2:0]         cand_cnt;
    logic               any_cand;
    logic [1:0]         pick_k;
    logic [1:0]         seen;
    logic [1:0]         sel_dir;
    logic [WALL_W-1:0]  cur_walls;
    logic [WALL_W-1:0]  cur_clr;
    logic [WALL_W-1:0]  nxt_new_walls;
    logic [CELL_W-1:0]  depth_m1;

    logic               mem_we;
    logic [CELL_W-1:0]  mem_wa;
    logic [WORD_W-1:0]  mem_wd;
    logic [CELL_W-1:0]  mem_ra;

    // effective grid, clamped to 1..max
    always_comb begin
        if (r_cols_cfg == '0) cols_act = CFG_W'(1);
        else if (r_cols_cfg > CFG_W'(MAX_COLUMNS)) cols_act = CFG_W'(MAX_COLUMNS);
        else cols_act = r_cols_cfg;
        if (r_rows_cfg == '0) rows_act = CFG_W'(1);
        else if (r_rows_cfg > CFG_W'(MAX_ROWS)) rows_act = CFG_W'(MAX_ROWS);
        else rows_act = r_rows_cfg;
    end

    assign total   = TOTAL_W'(cols_act) * TOTAL_W'(rows_act);
    assign cur_out = TOTAL_W'(r_cur) >= total;

    assign in_grid[DIR_TOP]    = r_row != '0;
    assign in_grid[DIR_RIGHT]  = (CFG_W'(r_col) + CFG_W'(1)) < cols_act;
    assign in_grid[DIR_BOTTOM] = (CFG_W'(r_row) + CFG_W'(1)) < rows_act;
    assign in_grid[DIR_LEFT]   = r_col != '0;

    assign nb_addr[DIR_TOP]    = r_cur - CELL_W'(cols_act);
    assign nb_addr[DIR_RIGHT]  = r_cur + CELL_W'(1);
    assign nb_addr[DIR_BOTTOM] = r_cur + CELL_W'(cols_act);
    assign nb_addr[DIR_LEFT]   = r_cur - CELL_W'(1);

    assign scan_dir  = 2'(r_scan - 3'd1);
    assign scan_addr = (r_scan == SCAN_CUR) ? r_cur : nb_addr[scan_dir];

    // candidates from the captured neighbour words
    always_comb begin
        for (int d = 0; d < 4; d++) begin
            cand[d] = in_grid[d] & ~r_slot[d + 1][WALL_W];
        end
    end

    assign cand_cnt = {2'b0, cand[0]} + {2'b0, cand[1]} + {2'b0, cand[2]} + {2'b0, cand[3]};
    assign any_cand = |cand;
    assign pick_k   = pick_index(cand_cnt, r_pick);

    // k-th candidate in top, right, bottom, left order
    always_comb begin
        sel_dir = DIR_TOP;
        seen    = 2'd0;
        for (int d = 0; d < 4; d++) begin
            if (cand[d]) begin
                if (seen == pick_k) sel_dir = 2'(d);
                seen = seen + 2'd1;
            end
        end
    end

    assign cur_walls     = r_slot[0][WALL_W-1:0];
    assign cur_clr       = any_cand ? (WALL_W'(1) << sel_dir) : '0;
    assign nxt_new_walls = r_nxt_walls & ~(WALL_W'(1) << 2'(r_dir + DIR_BOTTOM));
    assign depth_m1      = CELL_W'(r_depth - DEPTH_W'(1));

    // cell memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cur;
        mem_wd = {1'b1, cur_walls & ~cur_clr};
        if (i_cmd.clear_step) begin
            mem_we = 1'b1;
            mem_wa = r_clr_cnt;
            mem_wd = {1'b0, WALLS_ALL};
        end else if (i_cmd.decide) begin
            mem_we = 1'b1;
        end else if (i_cmd.carve) begin
            mem_we = 1'b1;
            mem_wa = r_nxt;
            mem_wd = {1'b1, nxt_new_walls};
        end
        if (i_cmd.scan_step) mem_ra = scan_addr;
        else if (r_op == OP_READ) mem_ra = r_addr;
        else mem_ra = r_cur;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) m_cell[mem_wa] <= mem_wd;
        r_mem_q <= m_cell[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.carve && (r_depth < DEPTH_W'(CELL_DEPTH))) m_trail[r_depth[CELL_W-1:0]] <= r_cur;
        if (i_cmd.decide) r_trail_q <= m_trail[depth_m1];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg   <= CFG_W'(32);
            r_rows_cfg   <= CFG_W'(32);
            r_cur        <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_geom_valid <= 1'b1;
            r_depth      <= '0;
            r_clr_cnt    <= '0;
            r_scan       <= SCAN_CUR;
            r_cap_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COLUMNS: r_cols_cfg <= i_cfg_data;
                    CFG_ROWS:    r_rows_cfg <= i_cfg_data;
                    default: ;
                endcase
                r_geom_valid <= 1'b0;
            end
            if (i_cmd.clear_step) r_clr_cnt <= r_clr_cnt + CELL_W'(1);
            if (i_cmd.restart || i_cmd.zero_cur) begin
                r_cur        <= '0;
                r_col        <= '0;
                r_row        <= '0;
                r_geom_valid <= 1'b1;
            end
            if (i_cmd.restart) r_depth <= '0;
            if (i_cmd.div_load) begin
                r_col        <= i_div_remainder[COL_W-1:0];
                r_row        <= i_div_quotient[ROW_W-1:0];
                r_geom_valid <= 1'b1;
            end
            if (i_cmd.scan_step) r_scan <= (r_scan == SCAN_LAST) ? SCAN_CUR : r_scan + 3'd1;
            r_cap_vld <= i_cmd.scan_step;
            if (i_cmd.decide && !any_cand && (r_depth != '0)) r_depth <= r_depth - DEPTH_W'(1);
            if (i_cmd.carve) begin
                r_cur <= r_nxt;
                case (r_dir)
                    DIR_TOP:    r_row <= r_row - ROW_W'(1);
                    DIR_RIGHT:  r_col <= r_col + COL_W'(1);
                    DIR_BOTTOM: r_row <= r_row + ROW_W'(1);
                    default:    r_col <= r_col - COL_W'(1);
                endcase
                if (r_depth < DEPTH_W'(CELL_DEPTH)) r_depth <= r_depth + DEPTH_W'(1);
            end
            if (i_cmd.pop_load) begin
                r_cur        <= r_trail_q;
                r_geom_valid <= 1'b0;
            end
            if (i_cmd.emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op          <= i_opcode;
            r_pick        <= i_pick;
            r_addr        <= i_cell_address;
            r_carved      <= 1'b0;
            r_backtracked <= 1'b0;
            r_finished    <= 1'b0;
        end
        r_cap_idx <= r_scan;
        if (r_cap_vld) r_slot[r_cap_idx] <= r_mem_q;
        if (i_cmd.decide) begin
            r_nxt         <= nb_addr[sel_dir];
            r_dir         <= sel_dir;
            r_nxt_walls   <= r_slot[3'(sel_dir) + 3'd1][WALL_W-1:0];
            r_carved      <= any_cand;
            r_backtracked <= !any_cand && (r_depth != '0);
            r_finished    <= !any_cand && (r_depth == '0);
            r_res_walls   <= cur_walls;
        end
        if (i_cmd.carve) r_res_walls <= nxt_new_walls;
        if (i_cmd.fetch_take) r_res_walls <= r_mem_q[WALL_W-1:0];
        if (i_cmd.emit) begin
            r_out_pos         <= r_cur;
            r_out_carved      <= r_carved;
            r_out_backtracked <= r_backtracked;
            r_out_finished    <= r_finished;
            r_out_walls       <= r_res_walls;
        end
    end

    assign o_stat.op          = r_op;
    assign o_stat.cur_out     = cur_out;
    assign o_stat.geom_valid  = r_geom_valid;
    assign o_stat.clr_last    = r_clr_cnt == CELL_W'(CELL_DEPTH - 1);
    assign o_stat.scan_last   = r_scan == SCAN_LAST;
    assign o_stat.any_cand    = any_cand;
    assign o_stat.stack_empty = r_depth == '0;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_div_dividend = r_cur;
    assign o_div_divisor  = cols_act;

    assign o_out_valid   = r_out_valid;
    assign o_position    = r_out_pos;
    assign o_carved      = r_out_carved;
    assign o_backtracked = r_out_backtracked;
    assign o_finished    = r_out_finished;
    assign o_wall_bits   = r_out_walls;

    // trail depth never runs past the stack
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(CELL_DEPTH))
        else $error("trail depth beyond stack size");

    // a result reports at most one of carved, backtracked, finished
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_out_carved, r_out_backtracked, r_out_finished}))
        else $error("more than one step flag in result");

    // tracked row and column agree with the cell index
    a_geom_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_geom_valid && !cur_out) |->
        (TOTAL_W'(r_row) * TOTAL_W'(cols_act) + TOTAL_W'(r_col) == TOTAL_W'(r_cur)))
        else $error("row/column tracking out of step with cell index");

endmodule

[hdl/maze_carver_backtracker_top.sv]
// maze_carver_backtracker_top: top level of the depth-first maze carver
// depends on mcb_pkg, mcb_item_if, mcb_res_if, mcb_div, mcb_ctrl, mcb_dp

// Depth-first (recursive backtracker) maze carver on a grid of up to 32 by 32
// cells. Each input beat carries an opcode: carve step, read cell walls or
// restart; every input beat produces exactly one result beat with the current
// position, the step flags and a 4-bit wall word (bit0 top, bit1 right,
// bit2 bottom, bit3 left). One item is worked at a time. After reset, and on
// every restart, the block sweeps its 1024-entry cell memory, one entry per
// cycle, setting all walls and clearing visited bits; input ready stays low
// during the sweep, while configuration writes are taken as usual. In a carve
// step the current cell and its four neighbours are read one by one through
// the single read port of the cell memory, then the decide and carve states
// write back the carved walls. When the row and column of the current cell are
// not known (after a backtrack or a column/row register write) the step first
// runs a restoring divider, and a backtrack passes through the pop, fetch and
// fetch-wait states to fetch the walls of the popped cell. Read and the unused
// opcode go from dispatch straight to the fetch states; restart runs the sweep
// first. The result sits in an output register, so the next beat is accepted
// while a result still waits. Configuration writes belong to idle periods.
module maze_carver_backtracker_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mcb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mcb_pkg::CFG_W-1:0]      i_cfg_data,
    mcb_item_if.sink                       i_item,
    mcb_res_if.source                      o_res
);
    import mcb_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic              div_done;
    logic [CELL_W-1:0] div_quotient;
    logic [CFG_W-1:0]  div_remainder;
    logic [CELL_W-1:0] div_dividend;
    logic [CFG_W-1:0]  div_divisor;
    logic              item_ready;

    // sequencer: one state per phase of an item
    mcb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .i_div_done   (div_done),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_item_ready (item_ready)
    );

    // splits the current cell index into row and column when they are unknown
    mcb_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    // memories, position state and the result register
    mcb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_item.opcode),
        .i_pick          (i_item.pick),
        .i_cell_address  (i_item.cell_address),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_div_quotient  (div_quotient),
        .i_div_remainder (div_remainder),
        .o_div_dividend  (div_dividend),
        .o_div_divisor   (div_divisor),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_position      (o_res.position),
        .o_carved        (o_res.carved),
        .o_backtracked   (o_res.backtracked),
        .o_finished      (o_res.finished),
        .o_wall_bits     (o_res.wall_bits)
    );

    // input beat taken only in the idle state
    assign i_item.ready = item_ready;

endmodule
